>>> rtl/ipt_pkg.sv
// Package for the inverter poll transaction block.
// Holds frame byte codes, field codes, the shared config and job structs and the CRC step.
// No dependencies.
`default_nettype none

package ipt_pkg;

    // Default buffer depth for reply collection
    localparam int BUF_BYTES_DEF = 128;

    // Input function codes (stream tuser)
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_RX    = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Transaction status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOREPLY = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_OTHER   = 2'd3;

    // Frame bytes
    localparam logic [7:0] BYTE_STX     = 8'h02;
    localparam logic [7:0] BYTE_ETX     = 8'h03;
    localparam logic [7:0] BYTE_REQ     = 8'h05;
    localparam logic [7:0] BYTE_ACK     = 8'h06;
    localparam logic [7:0] ADDR_REFUSED = 8'hFF;
    localparam logic [7:0] SUB_LIMIT    = 8'h80;

    // CRC-16/ARC, reflected polynomial
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Config register indexes (paddr[3:2])
    localparam logic [1:0] REG_ADDR    = 2'd0;
    localparam logic [1:0] REG_SILENCE = 2'd1;
    localparam logic [1:0] REG_WINDOW  = 2'd2;

    // Config register reset values
    localparam logic [7:0] RST_ADDR    = 8'd1;
    localparam logic [7:0] RST_SILENCE = 8'd50;
    localparam logic [9:0] RST_WINDOW  = 10'd300;

    typedef struct packed {
        logic [7:0] station_address;
        logic [7:0] silence_limit_ms;
        logic [9:0] window_limit_ms;
    } t_cfg;

    // Work handed from the collection core to the result sequencer
    typedef struct packed {
        logic        start;   // emit the nine request bytes
        logic        done;    // emit one finished result
        logic [1:0]  status;
        logic [15:0] value;
        logic [7:0]  cmd;
        logic [7:0]  sub;
    } t_job;

    // One byte through the CRC, LSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ipt_cfg.sv
// APB-style configuration registers of the inverter poll transaction block.
// Depends on ipt_pkg.
`default_nettype none

module ipt_cfg import ipt_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output      logic [31:0] o_prdata,
    output      t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic wr;

    assign wr = i_psel & i_penable & i_pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.station_address  <= RST_ADDR;
            r_cfg.silence_limit_ms <= RST_SILENCE;
            r_cfg.window_limit_ms  <= RST_WINDOW;
        end else if (wr) begin
            unique case (i_paddr[3:2])
                REG_ADDR:    r_cfg.station_address  <= i_pwdata[7:0];
                REG_SILENCE: r_cfg.silence_limit_ms <= i_pwdata[7:0];
                REG_WINDOW:  r_cfg.window_limit_ms  <= i_pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (i_paddr[3:2])
            REG_ADDR:    o_prdata = {24'd0, r_cfg.station_address};
            REG_SILENCE: o_prdata = {24'd0, r_cfg.silence_limit_ms};
            REG_WINDOW:  o_prdata = {22'd0, r_cfg.window_limit_ms};
            default:     o_prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/ipt_core.sv
// Reply collection core: transaction state, receive CRC, end detection and reply checks.
// Depends on ipt_pkg.
`default_nettype none

module ipt_core import ipt_pkg::*; #(
    parameter int BUFFER_BYTES = BUF_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [1:0] i_func,
    input  wire logic [7:0] i_cmd,
    input  wire logic [7:0] i_sub,
    input  wire logic [7:0] i_rx,
    input  wire t_cfg       i_cfg,
    output      t_job       o_job
);

    localparam logic [7:0] BufLim = 8'(BUFFER_BYTES);

    logic        r_collecting, n_collecting;
    logic [7:0]  r_pend_cmd, n_pend_cmd;
    logic [7:0]  r_pend_sub, n_pend_sub;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_cap [5];
    logic [7:0]  n_cap [5];
    logic [7:0]  r_lag [3];
    logic [7:0]  n_lag [3];
    logic [15:0] r_crc, n_crc;
    logic [9:0]  r_elapsed, n_elapsed;
    logic [7:0]  r_silence, n_silence;
    t_job        job;

    // Reply checks on the updated capture
    function automatic t_job finish_job(input logic [7:0] cnt, input logic [7:0] ack,
                                        input logic [7:0] ecmd, input logic [7:0] esub,
                                        input logic [7:0] hi, input logic [7:0] lo,
                                        input logic [7:0] pcmd, input logic [7:0] psub);
        t_job j;
        j = '0;
        j.done = 1'b1;
        if (cnt < 8'd10 || ack != BYTE_ACK) begin
            j.status = ST_NOREPLY;
        end else if (ecmd != pcmd || esub != psub) begin
            j.status = ST_OTHER;
        end else if (cnt < 8'd11) begin
            j.status = ST_NOREPLY;     // payload shorter than one word
        end else begin
            j.status = ST_OK;
            j.value  = {hi, lo};
        end
        return j;
    endfunction

    // Next state and job for the item in the input register
    always_comb begin
        n_collecting = r_collecting;
        n_pend_cmd   = r_pend_cmd;
        n_pend_sub   = r_pend_sub;
        n_cnt        = r_cnt;
        n_cap        = r_cap;
        n_lag        = r_lag;
        n_crc        = r_crc;
        n_elapsed    = r_elapsed;
        n_silence    = r_silence;
        job          = '0;
        case (i_func)
            FUNC_START: begin
                n_collecting = 1'b0;
                if (i_sub >= SUB_LIMIT || i_cfg.station_address == ADDR_REFUSED) begin
                    job.done   = 1'b1;
                    job.status = ST_REFUSED;
                end else begin
                    job.start    = 1'b1;
                    job.cmd      = i_cmd;
                    job.sub      = i_sub;
                    n_collecting = 1'b1;
                    n_pend_cmd   = i_cmd;
                    n_pend_sub   = i_sub;
                    n_cnt        = 8'd0;
                    n_cap        = '{default: 8'd0};
                    n_lag        = '{default: 8'd0};
                    n_crc        = 16'd0;
                    n_elapsed    = 10'd0;
                    n_silence    = 8'd0;
                end
            end
            FUNC_RX: begin
                if (r_collecting) begin
                    // capture ACK, echoed cmd/sub and first payload word
                    case (r_cnt)
                        8'd1: n_cap[0] = i_rx;
                        8'd4: n_cap[1] = i_rx;
                        8'd5: n_cap[2] = i_rx;
                        8'd6: n_cap[3] = i_rx;
                        8'd7: n_cap[4] = i_rx;
                        default: ;
                    endcase
                    // CRC trails the newest byte by three
                    if (r_cnt >= 8'd4) begin
                        n_crc = crc_feed(r_crc, r_lag[0]);
                    end
                    n_lag[0]  = r_lag[1];
                    n_lag[1]  = r_lag[2];
                    n_lag[2]  = i_rx;
                    n_cnt     = r_cnt + 8'd1;
                    n_silence = 8'd0;
                    if ((n_cnt >= 8'd10 && i_rx == BYTE_ETX && n_crc == {r_lag[2], r_lag[1]})
                        || n_cnt >= BufLim) begin
                        job = finish_job(n_cnt, n_cap[0], n_cap[1], n_cap[2], n_cap[3],
                                         n_cap[4], r_pend_cmd, r_pend_sub);
                        n_collecting = 1'b0;
                    end
                end
            end
            FUNC_TICK: begin
                if (r_collecting) begin
                    n_elapsed = (r_elapsed != 10'h3FF) ? r_elapsed + 10'd1 : r_elapsed;
                    n_silence = (r_silence != 8'hFF) ? r_silence + 8'd1 : r_silence;
                    if (n_elapsed >= i_cfg.window_limit_ms ||
                        n_silence > i_cfg.silence_limit_ms) begin
                        job = finish_job(r_cnt, r_cap[0], r_cap[1], r_cap[2], r_cap[3],
                                         r_cap[4], r_pend_cmd, r_pend_sub);
                        n_collecting = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // State update when the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_pend_cmd   <= 8'd0;
            r_pend_sub   <= 8'd0;
            r_cnt        <= 8'd0;
            r_cap        <= '{default: 8'd0};
            r_lag        <= '{default: 8'd0};
            r_crc        <= 16'd0;
            r_elapsed    <= 10'd0;
            r_silence    <= 8'd0;
        end else if (i_take) begin
            r_collecting <= n_collecting;
            r_pend_cmd   <= n_pend_cmd;
            r_pend_sub   <= n_pend_sub;
            r_cnt        <= n_cnt;
            r_cap        <= n_cap;
            r_lag        <= n_lag;
            r_crc        <= n_crc;
            r_elapsed    <= n_elapsed;
            r_silence    <= n_silence;
        end
    end

    assign o_job = job;

endmodule

`default_nettype wire

>>> rtl/ipt_emit.sv
// Result sequencer and output register: sends the request frame byte by byte,
// computing its CRC one byte per transfer, or a single finished result.
// Depends on ipt_pkg.
`default_nettype none

module ipt_emit import ipt_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire t_job        i_job,
    input  wire logic [7:0]  i_station,
    input  wire logic        i_tready,
    output      logic        o_free,
    output      logic        o_tvalid,
    output      logic        o_kind,
    output      logic [7:0]  o_tx,
    output      logic [1:0]  o_status,
    output      logic [15:0] o_value,
    output      logic        o_last
);

    logic        r_ovalid;
    logic        r_frame;
    logic [3:0]  r_seq;
    logic [15:0] r_txcrc;
    logic [7:0]  r_cmd;
    logic [7:0]  r_sub;
    logic        r_kind;
    logic [7:0]  r_tx;
    logic [1:0]  r_status;
    logic [15:0] r_value;
    logic        r_last;
    logic        fire;
    logic        adv;
    logic [7:0]  sel;

    assign fire   = r_ovalid & i_tready;
    assign adv    = ~r_ovalid | i_tready;
    assign o_free = ~r_frame & adv;

    // Request byte at the current frame position
    always_comb begin
        case (r_seq)
            4'd1:    sel = BYTE_REQ;
            4'd2:    sel = i_station;
            4'd3:    sel = BYTE_STX;
            4'd4:    sel = r_cmd;
            4'd5:    sel = r_sub;
            4'd6:    sel = r_txcrc[7:0];
            4'd7:    sel = r_txcrc[15:8];
            4'd8:    sel = BYTE_ETX;
            default: sel = BYTE_STX;
        endcase
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_frame  <= 1'b0;
            r_seq    <= 4'd0;
        end else if (i_load) begin
            r_ovalid <= 1'b1;
            r_frame  <= i_job.start;
            r_seq    <= 4'd1;
        end else if (adv && r_frame) begin
            r_ovalid <= 1'b1;
            r_seq    <= r_seq + 4'd1;
            if (r_seq == 4'd8) begin
                r_frame <= 1'b0;
            end
        end else if (fire) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output register and frame CRC
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmd    <= i_job.cmd;
            r_sub    <= i_job.sub;
            r_txcrc  <= 16'd0;
            r_kind   <= i_job.start ? KIND_TX : KIND_DONE;
            r_tx     <= i_job.start ? BYTE_STX : 8'd0;
            r_status <= i_job.start ? ST_OK : i_job.status;
            r_value  <= i_job.start ? 16'd0 : i_job.value;
            r_last   <= ~i_job.start;
        end else if (adv && r_frame) begin
            if (r_seq >= 4'd1 && r_seq <= 4'd5) begin
                r_txcrc <= crc_feed(r_txcrc, sel);
            end
            r_kind   <= KIND_TX;
            r_tx     <= sel;
            r_status <= ST_OK;
            r_value  <= 16'd0;
            r_last   <= (r_seq == 4'd8);
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_kind   = r_kind;
    assign o_tx     = r_tx;
    assign o_status = r_status;
    assign o_value  = r_value;
    assign o_last   = r_last;

endmodule

`default_nettype wire

>>> rtl/inverter_poll_transaction.sv
// Top level of the inverter poll transaction block: input register, config port,
// collection core and result sequencer. Depends on ipt_pkg, ipt_cfg, ipt_core, ipt_emit.
//
// A start transfer produces the nine-byte CRC-16/ARC request on nine output transfers,
// one per cycle while the sink is ready, then the block collects reply bytes and ticks;
// the transaction ends with one finished transfer carrying status and the big-endian
// payload word. A start with subcommand 0x80 or above or station address 0xFF yields one
// refused result instead. Results pass the input register, then the output register.
// Received bytes and ticks are accepted back to back; an item that yields results waits
// only while the output sequencer still holds earlier results, so a start holds the output
// until its nine request bytes are sent. Bytes and ticks with no open transaction are dropped.
`default_nettype none

module inverter_poll_transaction import ipt_pkg::*; #(
    parameter int BUFFER_BYTES = BUF_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // command[7:0], subcommand[15:8], rx_byte[23:16]
    input  wire logic [1:0]  i_s_axis_tuser,   // func[1:0]
    // result stream
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output      logic [31:0] o_m_axis_tdata,   // tx_byte[7:0], status[9:8], reply_value[25:10]
    output      logic        o_m_axis_tuser,   // kind
    output      logic        o_m_axis_tlast,
    // config port
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output      logic [31:0] o_prdata,
    output      logic        o_pready
);

    logic        r_in_valid;
    logic [23:0] r_in_data;
    logic [1:0]  r_in_func;
    logic        take;
    logic        emit_free;
    t_cfg        cfg;
    t_job        job;
    logic        kind;
    logic [7:0]  tx;
    logic [1:0]  status;
    logic [15:0] value;

    // Item leaves the input register once the sequencer can take its results
    assign take            = r_in_valid & (~(job.start | job.done) | emit_free);
    assign o_s_axis_tready = ~r_in_valid | take;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
            r_in_func <= i_s_axis_tuser;
        end
    end

    ipt_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_cfg     (cfg)
    );

    ipt_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_func  (r_in_func),
        .i_cmd   (r_in_data[7:0]),
        .i_sub   (r_in_data[15:8]),
        .i_rx    (r_in_data[23:16]),
        .i_cfg   (cfg),
        .o_job   (job)
    );

    ipt_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (take & (job.start | job.done)),
        .i_job     (job),
        .i_station (cfg.station_address),
        .i_tready  (i_m_axis_tready),
        .o_free    (emit_free),
        .o_tvalid  (o_m_axis_tvalid),
        .o_kind    (kind),
        .o_tx      (tx),
        .o_status  (status),
        .o_value   (value),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {6'd0, value, status, tx};
    assign o_m_axis_tuser = kind;
    assign o_pready       = 1'b1;

endmodule

`default_nettype wire
